>>> hdl/otsu_three_threshold_quantizer_defines.svh
// Assertion macros used by the quantizer checker.
`ifndef OTSU_THREE_THRESHOLD_QUANTIZER_DEFINES_SVH
`define OTSU_THREE_THRESHOLD_QUANTIZER_DEFINES_SVH

// same-cycle implication
`define OTQ_ASSERT_SAME(label, clk_i, rst_ni, cond, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define OTQ_ASSERT_NEXT(label, clk_i, rst_ni, cond, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> hdl/otq_pkg.sv
// Types and constants of the three-threshold quantizer.
package otq_pkg;

	localparam int PIX_W       = 8;
	localparam int BINS        = 256;
	localparam int SCORE_W     = 64;
	localparam int SCORE_SHIFT = 16;
	localparam int IN_DATA_W   = 8;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 40;
	localparam int OUT_USER_W  = 1;

	localparam logic [PIX_W-1:0] F_LAST   = 8'd254;
	localparam logic [PIX_W-1:0] LVL_ZERO = 8'd0;
	localparam logic [PIX_W-1:0] LVL_ONE  = 8'd84;
	localparam logic [PIX_W-1:0] LVL_TWO  = 8'd170;
	localparam logic [PIX_W-1:0] LVL_TOP  = 8'd255;

	localparam logic KIND_THR = 1'b0;
	localparam logic KIND_PIX = 1'b1;

	typedef enum logic [1:0] {
		REQ_ACC = 2'd0,
		REQ_FIN = 2'd1,
		REQ_CLS = 2'd2
	} req_t;

	// class whose score is being computed
	typedef enum logic [1:0] {
		SC_C0 = 2'd0,
		SC_C1 = 2'd1,
		SC_C2 = 2'd2,
		SC_C3 = 2'd3
	} sel_t;

	typedef enum logic [16:0] {
		ST_IDLE    = 17'h00001,
		ST_ACC_WR  = 17'h00002,
		ST_PFX     = 17'h00004,
		ST_MEAN_GO = 17'h00008,
		ST_MEAN_WT = 17'h00010,
		ST_F0_RD   = 17'h00020,
		ST_F0_CHK  = 17'h00040,
		ST_F1_RD   = 17'h00080,
		ST_F1_CHK  = 17'h00100,
		ST_F2_RD   = 17'h00200,
		ST_F2_CHK  = 17'h00400,
		ST_SC_QM   = 17'h00800,
		ST_SC_D    = 17'h01000,
		ST_SC_SQ   = 17'h02000,
		ST_SC_DIV  = 17'h04000,
		ST_SC_ACC  = 17'h08000,
		ST_EMIT    = 17'h10000
	} state_t;

	typedef struct packed {
		logic cls;
		logic acc_rd;
		logic acc_wr;
		logic pfx_init;
		logic pfx_step;
		logic srch_init;
		logic mean_go;
		logic mean_take;
		logic rd_f0;
		logic rd_f1;
		logic rd_f2;
		logic take_f0;
		logic take_f1;
		logic take_f2;
		logic inc_f0;
		logic set_f1;
		logic inc_f1;
		logic set_f2;
		logic inc_f2;
		logic sc_qm;
		logic sq_go;
		logic div_go;
		logic sc_acc;
		sel_t sel;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic acc_ok;
		logic pfx_last;
		logic n_zero;
		logic div_done;
		logic sq_done;
		logic out_busy;
		logic q0_zero;
		logic q1_zero;
		logic q23_zero;
		logic f0_last;
		logic f1_last;
		logic f2_last;
	} sts_t;

endpackage

>>> hdl/otq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module otq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/otq_div.sv
// Restoring divider, one quotient bit per cycle.
module otq_div #(
	parameter int NW = 80,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quot,
	output logic          done
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_nx;
	logic          ge;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= rem_nx[DW-1:0];
		end
	end

	assign quot = num_q;
	assign done = done_q;

endmodule

>>> hdl/otq_sqr.sv
// Shift-add squarer, one multiplier bit per cycle.
module otq_sqr #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [W-1:0]   d,
	output logic [2*W-1:0] prod,
	output logic           done
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0]  cnt_q;
	logic           done_q;
	logic [W-1:0]   mc_q;
	logic [2*W-1:0] p_q;
	logic [W:0]     sum;

	assign sum = p_q[0] ? {1'b0, p_q[2*W-1:W]} + {1'b0, mc_q} : {1'b0, p_q[2*W-1:W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mc_q <= d;
			p_q  <= {{W{1'b0}}, d};
		end else if (cnt_q != '0) begin
			p_q <= {sum, p_q[W-1:1]};
		end
	end

	assign prod = p_q;
	assign done = done_q;

endmodule

>>> hdl/otq_ctrl.sv
// Sequencer: accept, histogram update, prefix sweep and threshold search.
module otq_ctrl import otq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic [IN_USER_W-1:0] in_type,
	output logic                 s_tready,
	input  sts_t                 sts,
	output cmd_t                 cmd
);

	state_t state_q, nxt;
	sel_t   sel_q, sel_d;
	logic   in_acc;
	logic   a0, a1, a2;

	assign s_tready = (state_q == ST_IDLE) & ~sts.out_busy;
	assign in_acc   = s_tvalid & s_tready;

	always_comb begin
		cmd     = '0;
		nxt     = state_q;
		sel_d   = sel_q;
		cmd.sel = sel_q;
		a0      = 1'b0;
		a1      = 1'b0;
		a2      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (req_t'(in_type))
						REQ_ACC: begin
							if (sts.acc_ok) begin
								cmd.acc_rd = 1'b1;
								nxt        = ST_ACC_WR;
							end
						end
						REQ_FIN: begin
							cmd.pfx_init = 1'b1;
							nxt          = ST_PFX;
						end
						REQ_CLS: cmd.cls = 1'b1;
						default: ;
					endcase
				end
			end
			ST_ACC_WR: begin
				cmd.acc_wr = 1'b1;
				nxt        = ST_IDLE;
			end
			ST_PFX: begin
				cmd.pfx_step = 1'b1;
				if (sts.pfx_last) begin
					nxt = ST_MEAN_GO;
				end
			end
			ST_MEAN_GO: begin
				cmd.srch_init = 1'b1;
				if (sts.n_zero) begin
					nxt = ST_EMIT;
				end else begin
					cmd.mean_go = 1'b1;
					nxt         = ST_MEAN_WT;
				end
			end
			ST_MEAN_WT: begin
				if (sts.div_done) begin
					cmd.mean_take = 1'b1;
					nxt           = ST_F0_RD;
				end
			end
			ST_F0_RD: begin
				cmd.rd_f0 = 1'b1;
				nxt       = ST_F0_CHK;
			end
			ST_F0_CHK: begin
				cmd.take_f0 = 1'b1;
				if (sts.q0_zero) begin
					a0 = 1'b1;
				end else begin
					sel_d = SC_C0;
					nxt   = ST_SC_QM;
				end
			end
			ST_F1_RD: begin
				cmd.rd_f1 = 1'b1;
				nxt       = ST_F1_CHK;
			end
			ST_F1_CHK: begin
				cmd.take_f1 = 1'b1;
				if (sts.q1_zero) begin
					a1 = 1'b1;
				end else begin
					sel_d = SC_C1;
					nxt   = ST_SC_QM;
				end
			end
			ST_F2_RD: begin
				cmd.rd_f2 = 1'b1;
				nxt       = ST_F2_CHK;
			end
			ST_F2_CHK: begin
				cmd.take_f2 = 1'b1;
				if (sts.q23_zero) begin
					a2 = 1'b1;
				end else begin
					sel_d = SC_C2;
					nxt   = ST_SC_QM;
				end
			end
			ST_SC_QM: begin
				cmd.sc_qm = 1'b1;
				nxt       = ST_SC_D;
			end
			ST_SC_D: begin
				cmd.sq_go = 1'b1;
				nxt       = ST_SC_SQ;
			end
			ST_SC_SQ: begin
				if (sts.sq_done) begin
					cmd.div_go = 1'b1;
					nxt        = ST_SC_DIV;
				end
			end
			ST_SC_DIV: begin
				if (sts.div_done) begin
					nxt = ST_SC_ACC;
				end
			end
			ST_SC_ACC: begin
				cmd.sc_acc = 1'b1;
				unique case (sel_q)
					SC_C0: begin
						if (sts.f0_last) begin
							nxt = ST_EMIT;
						end else begin
							cmd.set_f1 = 1'b1;
							nxt        = ST_F1_RD;
						end
					end
					SC_C1: begin
						if (sts.f1_last) begin
							a0 = 1'b1;
						end else begin
							cmd.set_f2 = 1'b1;
							nxt        = ST_F2_RD;
						end
					end
					SC_C2: begin
						sel_d = SC_C3;
						nxt   = ST_SC_QM;
					end
					SC_C3: a2 = 1'b1;
					default: ;
				endcase
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				nxt      = ST_IDLE;
			end
			default: nxt = ST_IDLE;
		endcase

		// loop advance: innermost first, carry outward
		if (a2) begin
			if (!sts.f2_last) begin
				cmd.inc_f2 = 1'b1;
				nxt        = ST_F2_RD;
			end else begin
				a1 = 1'b1;
			end
		end
		if (a1) begin
			if (!sts.f1_last) begin
				cmd.inc_f1 = 1'b1;
				nxt        = ST_F1_RD;
			end else begin
				a0 = 1'b1;
			end
		end
		if (a0) begin
			if (!sts.f0_last) begin
				cmd.inc_f0 = 1'b1;
				nxt        = ST_F0_RD;
			end else begin
				nxt = ST_EMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SC_C0;
		end else begin
			state_q <= nxt;
			sel_q   <= sel_d;
		end
	end

endmodule

>>> hdl/otq_datapath.sv
// Histogram, prefix tables, score unit, best-split registers and output register.
module otq_datapath import otq_pkg::*; #(
	parameter int PCB = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [PIX_W-1:0] pixel,
	input  logic             m_tready,
	output logic             out_valid,
	output logic             out_kind,
	output logic [PIX_W-1:0] out_level,
	output logic [PIX_W-1:0] out_low,
	output logic [PIX_W-1:0] out_mid,
	output logic [PIX_W-1:0] out_high,
	output logic             out_found
);

	localparam int IW = PCB + PIX_W;
	localparam int NW = 2 * IW + SCORE_SHIFT;

	logic [PIX_W-1:0]   pix_q;
	logic [BINS-1:0]    hvld_q;
	logic               hvld_s1;
	logic [PCB-1:0]     total_q;
	logic [PIX_W:0]     k_q;
	logic [PIX_W-1:0]   pidx_s1;
	logic [PCB-1:0]     cc_q;
	logic [IW-1:0]      ci_q;

	logic               h_re;
	logic [PIX_W-1:0]   h_raddr;
	logic [PCB-1:0]     h_rdata;
	logic [PCB-1:0]     h_cnt;
	logic               c_re;
	logic               c_we;
	logic [PIX_W-1:0]   c_raddr;
	logic [PCB-1:0]     cc_rd;
	logic [IW-1:0]      ci_rd;
	logic [PCB-1:0]     cc_new;
	logic [IW-1:0]      wprod;
	logic [IW-1:0]      ci_new;

	logic [PIX_W-1:0]   mean_q;
	logic [PIX_W-1:0]   f0_q, f1_q, f2_q;
	logic [PCB-1:0]     c0_q, c1_q, c2_q;
	logic [IW-1:0]      i0_q, i1_q, i2_q;
	logic [PCB-1:0]     q_sel;
	logic [IW-1:0]      s_sel;
	logic [PCB-1:0]     sq_den_q;
	logic [IW-1:0]      ss_q;
	logic [IW-1:0]      qm_q;
	logic [IW-1:0]      dabs;

	logic [2*IW-1:0]    sq_prod;
	logic               sq_done;
	logic               dv_go;
	logic [NW-1:0]      dv_num;
	logic [PCB-1:0]     dv_den;
	logic [NW-1:0]      dv_quot;
	logic               dv_done;
	logic [SCORE_W-1:0] sc_v;
	logic [SCORE_W-1:0] s0_q, s1_q, part_q, best_q, sum;
	logic [PIX_W-1:0]   t0_q, t1_q, t2_q;
	logic               found_q;
	logic               out_valid_q;
	logic [PIX_W-1:0]   lvl;

	// histogram
	assign h_re    = cmd.acc_rd | (cmd.pfx_step & ~k_q[PIX_W]);
	assign h_raddr = cmd.acc_rd ? pixel : k_q[PIX_W-1:0];
	assign h_cnt   = hvld_s1 ? h_rdata : '0;

	otq_ram #(.WIDTH(PCB), .DEPTH(BINS)) u_hist (
		.clk   (clk),
		.we    (cmd.acc_wr),
		.waddr (pix_q),
		.wdata (h_cnt + PCB'(1)),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// prefix tables
	assign wprod   = h_cnt * pidx_s1;
	assign cc_new  = cc_q + h_cnt;
	assign ci_new  = ci_q + wprod;
	assign c_we    = cmd.pfx_step & (k_q != '0);
	assign c_re    = cmd.rd_f0 | cmd.rd_f1 | cmd.rd_f2;
	assign c_raddr = cmd.rd_f0 ? f0_q : (cmd.rd_f1 ? f1_q : f2_q);

	otq_ram #(.WIDTH(PCB), .DEPTH(BINS)) u_cum_cnt (
		.clk   (clk),
		.we    (c_we),
		.waddr (pidx_s1),
		.wdata (cc_new),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (cc_rd)
	);

	otq_ram #(.WIDTH(IW), .DEPTH(BINS)) u_cum_int (
		.clk   (clk),
		.we    (c_we),
		.waddr (pidx_s1),
		.wdata (ci_new),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (ci_rd)
	);

	// score operands
	always_comb begin
		unique case (cmd.sel)
			SC_C0: begin
				q_sel = c0_q;
				s_sel = i0_q;
			end
			SC_C1: begin
				q_sel = c1_q - c0_q;
				s_sel = i1_q - i0_q;
			end
			SC_C2: begin
				q_sel = c2_q - c1_q;
				s_sel = i2_q - i1_q;
			end
			default: begin
				q_sel = cc_q - c2_q;
				s_sel = ci_q - i2_q;
			end
		endcase
	end

	assign dabs = (ss_q >= qm_q) ? ss_q - qm_q : qm_q - ss_q;

	otq_sqr #(.W(IW)) u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.sq_go),
		.d      (dabs),
		.prod   (sq_prod),
		.done   (sq_done)
	);

	assign dv_go  = cmd.mean_go | cmd.div_go;
	assign dv_num = cmd.mean_go ? NW'(ci_q) : {sq_prod, {SCORE_SHIFT{1'b0}}};
	assign dv_den = cmd.mean_go ? cc_q : sq_den_q;

	otq_div #(.NW(NW), .DW(PCB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (dv_go),
		.num    (dv_num),
		.den    (dv_den),
		.quot   (dv_quot),
		.done   (dv_done)
	);

	assign sc_v = SCORE_W'(dv_quot);
	assign sum  = part_q + sc_v;

	always_comb begin
		if (pixel <= t0_q) begin
			lvl = LVL_ZERO;
		end else if (pixel <= t1_q) begin
			lvl = LVL_ONE;
		end else if (pixel <= t2_q) begin
			lvl = LVL_TWO;
		end else begin
			lvl = LVL_TOP;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvld_q      <= '0;
			total_q     <= '0;
			k_q         <= '0;
			t0_q        <= '0;
			t1_q        <= '0;
			t2_q        <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc_wr) begin
				hvld_q[pix_q] <= 1'b1;
				total_q       <= total_q + PCB'(1);
			end
			if (cmd.pfx_init) begin
				k_q <= '0;
			end else if (cmd.pfx_step) begin
				k_q <= k_q + (PIX_W + 1)'(1);
				if (k_q[PIX_W]) begin
					hvld_q  <= '0;
					total_q <= '0;
				end
			end
			if (cmd.srch_init) begin
				best_q  <= '0;
				t0_q    <= '0;
				t1_q    <= '0;
				t2_q    <= '0;
				found_q <= 1'b0;
			end else if (cmd.sc_acc && cmd.sel == SC_C3 && sum > best_q) begin
				best_q  <= sum;
				t0_q    <= f0_q;
				t1_q    <= f1_q;
				t2_q    <= f2_q;
				found_q <= 1'b1;
			end
			if (cmd.cls || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.acc_rd) begin
			pix_q <= pixel;
		end
		if (h_re) begin
			hvld_s1 <= hvld_q[h_raddr];
			pidx_s1 <= h_raddr;
		end
		if (cmd.pfx_init) begin
			cc_q <= '0;
			ci_q <= '0;
		end else if (c_we) begin
			cc_q <= cc_new;
			ci_q <= ci_new;
		end
		if (cmd.mean_take) begin
			mean_q <= dv_quot[PIX_W-1:0];
			f0_q   <= '0;
		end else if (cmd.inc_f0) begin
			f0_q <= f0_q + PIX_W'(1);
		end
		if (cmd.set_f1) begin
			f1_q <= f0_q + PIX_W'(1);
		end else if (cmd.inc_f1) begin
			f1_q <= f1_q + PIX_W'(1);
		end
		if (cmd.set_f2) begin
			f2_q <= f1_q + PIX_W'(1);
		end else if (cmd.inc_f2) begin
			f2_q <= f2_q + PIX_W'(1);
		end
		if (cmd.take_f0) begin
			c0_q <= cc_rd;
			i0_q <= ci_rd;
		end
		if (cmd.take_f1) begin
			c1_q <= cc_rd;
			i1_q <= ci_rd;
		end
		if (cmd.take_f2) begin
			c2_q <= cc_rd;
			i2_q <= ci_rd;
		end
		if (cmd.sc_qm) begin
			sq_den_q <= q_sel;
			ss_q     <= s_sel;
			qm_q     <= q_sel * mean_q;
		end
		if (cmd.sc_acc) begin
			unique case (cmd.sel)
				SC_C0: s0_q   <= sc_v;
				SC_C1: s1_q   <= s0_q + sc_v;
				SC_C2: part_q <= s1_q + sc_v;
				default: ;
			endcase
		end
		if (cmd.cls) begin
			out_kind  <= KIND_PIX;
			out_level <= lvl;
			out_low   <= '0;
			out_mid   <= '0;
			out_high  <= '0;
			out_found <= 1'b0;
		end else if (cmd.emit) begin
			out_kind  <= KIND_THR;
			out_level <= LVL_ZERO;
			out_low   <= t0_q;
			out_mid   <= t1_q;
			out_high  <= t2_q;
			out_found <= found_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.acc_ok   = ~&total_q;
		sts.pfx_last = k_q[PIX_W];
		sts.n_zero   = cc_q == '0;
		sts.div_done = dv_done;
		sts.sq_done  = sq_done;
		sts.out_busy = out_valid_q;
		sts.q0_zero  = cc_rd == '0;
		sts.q1_zero  = cc_rd == c0_q;
		sts.q23_zero = (cc_rd == c1_q) | (cc_rd == cc_q);
		sts.f0_last  = f0_q == F_LAST;
		sts.f1_last  = f1_q == F_LAST;
		sts.f2_last  = f2_q == F_LAST;
	end

endmodule

>>> hdl/otsu_three_threshold_quantizer.sv
// Top level of the three-threshold gray-level quantizer.
//
//  channel | dir | tdata                   | tuser
//  s_*     | in  | pixel[7:0]              | req_type[1:0]
//  m_*     | out | level, low, mid, high,  | result_kind[0]
//          |     | found (bits 0..32)      |
//
// Accumulate: histogram RAM read, then write. Classify: level registered into the output.
// Finish: prefix sweep, a mean divide, then for each scored class a square and a
// divide on the shared squarer and divider.
// Reset clears the histogram valid bits at once; no clearing pass.
// s_tready is high only when idle with the output register empty.
module otsu_three_threshold_quantizer import otq_pkg::*; #(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // pixel
	input  logic [IN_USER_W-1:0]  s_tuser,  // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // level, low, mid, high, found, pad
	output logic [OUT_USER_W-1:0] m_tuser   // result_kind
);

	cmd_t             cmd;
	sts_t             sts;
	logic             out_kind;
	logic [PIX_W-1:0] out_level, out_low, out_mid, out_high;
	logic             out_found;

	otq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_type  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	otq_datapath #(.PCB(PIXEL_COUNT_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pixel     (s_tdata),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_kind  (out_kind),
		.out_level (out_level),
		.out_low   (out_low),
		.out_mid   (out_mid),
		.out_high  (out_high),
		.out_found (out_found)
	);

	assign m_tdata = {7'b0, out_found, out_high, out_mid, out_low, out_level};
	assign m_tuser = out_kind;

endmodule

>>> hdl/otq_checker.sv
// Port-level checks of the quantizer, bound to the top level.
`include "otsu_three_threshold_quantizer_defines.svh"

module otq_checker import otq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [IN_USER_W-1:0]  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	logic [PIX_W-1:0] lvl, lo, mi, hi;
	logic             fnd;
	logic             pix_res, thr_res, cls_in;

	assign lvl     = m_tdata[7:0];
	assign lo      = m_tdata[15:8];
	assign mi      = m_tdata[23:16];
	assign hi      = m_tdata[31:24];
	assign fnd     = m_tdata[32];
	assign pix_res = m_tvalid && m_tuser[0] == KIND_PIX;
	assign thr_res = m_tvalid && m_tuser[0] == KIND_THR;
	assign cls_in  = s_tvalid && s_tready && s_tuser == REQ_CLS;

	`OTQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`OTQ_ASSERT_SAME(a_no_in_when_full, clk, arst_n, m_tvalid, !s_tready, "input taken with result pending")
	`OTQ_ASSERT_SAME(a_pix_level, clk, arst_n, pix_res, (lvl == LVL_ZERO || lvl == LVL_ONE || lvl == LVL_TWO || lvl == LVL_TOP) && m_tdata[32:8] == '0, "bad classified pixel")
	`OTQ_ASSERT_SAME(a_thr_order, clk, arst_n, thr_res, lvl == LVL_ZERO && ((fnd && lo < mi && mi < hi && hi <= F_LAST) || (!fnd && lo == '0 && mi == '0 && hi == '0)), "bad threshold result")
	`OTQ_ASSERT_NEXT(a_cls_result, clk, arst_n, cls_in, m_tvalid && m_tuser[0] == KIND_PIX, "classify gave no result")

endmodule

bind otsu_three_threshold_quantizer otq_checker u_otq_checker (.*);
